// File: rtl/bgmc_pkg.sv
// ----------------------------------------------------------------------------
// bgmc_pkg
// Shared types, constants and helpers for the binary glyph match counter.
// ----------------------------------------------------------------------------
package bgmc_pkg;

   // configuration port
   localparam int CFG_W     = 11;
   localparam int CSR_IDX_W = 1;

   typedef logic [CSR_IDX_W-1:0] csr_index_type;

   localparam csr_index_type REG_IMAGE_WIDTH  = 1'd0;
   localparam csr_index_type REG_IMAGE_HEIGHT = 1'd1;

   // default frame size after reset
   localparam int RESET_SIZE = 1024;

   // line history: four previous rows per column
   localparam int HIST_W = 4;

   // window: bit 5*col + row, col 4 newest, row 4 current row
   localparam int WIN_W = 25;
   localparam logic [WIN_W-1:0] GLYPH_PATTERN   = 25'h00711C0;
   localparam logic [WIN_W-1:0] UPPER_ROWS_MASK = 25'h0F7BDEF;

   // match counter
   localparam int COUNT_W = 17;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 17'h1FFFF;

   // channel payloads
   typedef struct packed {
      logic pixel_set;
   } req_payload_type;

   typedef struct packed {
      logic [COUNT_W-1:0] match_count;
   } rsp_payload_type;

   // exact compare of one window against the glyph with its blank ring
   function automatic logic glyph_hit(input logic [WIN_W-1:0] win);
      return (win == GLYPH_PATTERN);
   endfunction

endpackage

// File: rtl/bgmc_stream_if.sv
// ----------------------------------------------------------------------------
// bgmc_stream_if
// Valid/ready stream channel carrying one payload per request.
// ----------------------------------------------------------------------------
interface bgmc_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (
      output valid,
      output payload,
      input  ready
   );

   modport sink (
      input  valid,
      input  payload,
      output ready
   );
endinterface

// File: rtl/binary_glyph_match_counter_top.sv
// ----------------------------------------------------------------------------
// binary_glyph_match_counter_top
// Counts 3x3 'H' glyphs with a blank one-pixel ring in a binary raster
// streamed one pixel per request, row-major; emits the count per frame.
// ----------------------------------------------------------------------------
// Throughput: one pixel request per cycle, sustained; a frame's last pixel
//   waits in the window stage only while the previous count is unclaimed.
// Result path: the history is read at the accept edge and the window stage
//   loads the result register when it fires; the count is offered from there.
// Reset: synchronous, active high; frame size returns to 1024 x 1024 (or the
//   maximum if smaller), positions, window and count clear. History memory
//   is not cleared; rows above the frame top are masked off.
// ----------------------------------------------------------------------------
module binary_glyph_match_counter_top #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   bgmc_stream_if.sink                   req_if,
   bgmc_stream_if.source                 rsp_if,
   input  logic                          csr_wr_en,
   input  bgmc_pkg::csr_index_type       csr_index,
   input  logic [bgmc_pkg::CFG_W-1:0]    csr_wdata
);

   localparam int CPW    = $clog2(MAX_WIDTH);
   localparam int RPW    = $clog2(MAX_HEIGHT);
   localparam int WSZ_W  = $clog2(MAX_WIDTH + 1);
   localparam int HSZ_W  = $clog2(MAX_HEIGHT + 1);
   localparam int WCMP_W = (WSZ_W > bgmc_pkg::CFG_W) ? WSZ_W : bgmc_pkg::CFG_W;
   localparam int HCMP_W = (HSZ_W > bgmc_pkg::CFG_W) ? HSZ_W : bgmc_pkg::CFG_W;
   localparam int RST_WIDTH  =
      (MAX_WIDTH < bgmc_pkg::RESET_SIZE) ? MAX_WIDTH : bgmc_pkg::RESET_SIZE;
   localparam int RST_HEIGHT =
      (MAX_HEIGHT < bgmc_pkg::RESET_SIZE) ? MAX_HEIGHT : bgmc_pkg::RESET_SIZE;
   localparam int WIN_W   = bgmc_pkg::WIN_W;
   localparam int HIST_W  = bgmc_pkg::HIST_W;
   localparam int COUNT_W = bgmc_pkg::COUNT_W;

   // frame size registers (stored already clamped)
   logic [WSZ_W-1:0] width_ff, width_in;
   logic [HSZ_W-1:0] height_ff, height_in;

   // scan position
   logic [CPW-1:0] col_pos_ff, col_pos_in;
   logic [RPW-1:0] row_pos_ff, row_pos_in;

   // window stage
   logic              s1_valid_ff, s1_valid_in;
   logic              s1_pix_ff;
   logic [CPW-1:0]    s1_col_ff;
   logic [HIST_W-1:0] s1_keep_ff;
   logic              s1_first_col_ff;
   logic              s1_last_col_ff;
   logic              s1_last_row_ff;

   logic [WIN_W-1:0]   win_ff, win_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0] rsp_count_ff;

   logic              req_accept;
   logic              s1_fire;
   logic              last_col;
   logic              last_row;
   logic [WSZ_W-1:0]  col_next;
   logic [HSZ_W-1:0]  row_next;
   logic [HIST_W-1:0] keep;
   logic [HIST_W-1:0] hist_rd;
   logic [HIST_W:0]   column;
   logic [WIN_W-1:0]  win_base;
   logic [WIN_W-1:0]  win_new;
   logic [WIN_W-1:0]  below;
   logic [2:0]        add;
   logic [COUNT_W:0]  sum;
   logic [COUNT_W-1:0] count_sat;

   // ---------------------------------------------------------------- config
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            bgmc_pkg::REG_IMAGE_WIDTH: begin
               if (csr_wdata == '0) begin
                  width_in = WSZ_W'(1);
               end else if (WCMP_W'(csr_wdata) > WCMP_W'(MAX_WIDTH)) begin
                  width_in = WSZ_W'(MAX_WIDTH);
               end else begin
                  width_in = WSZ_W'(csr_wdata);
               end
            end
            bgmc_pkg::REG_IMAGE_HEIGHT: begin
               if (csr_wdata == '0) begin
                  height_in = HSZ_W'(1);
               end else if (HCMP_W'(csr_wdata) > HCMP_W'(MAX_HEIGHT)) begin
                  height_in = HSZ_W'(MAX_HEIGHT);
               end else begin
                  height_in = HSZ_W'(csr_wdata);
               end
            end
            default: begin
            end
         endcase
      end
   end

   // ------------------------------------------------------------ handshake
   assign s1_fire = s1_valid_ff &&
                    (!(s1_last_col_ff && s1_last_row_ff) || !rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = !s1_valid_ff || s1_fire;
   assign req_accept   = req_if.valid && req_if.ready;

   // ------------------------------------------------------ position tracking
   assign col_next = WSZ_W'(col_pos_ff) + WSZ_W'(1);
   assign row_next = HSZ_W'(row_pos_ff) + HSZ_W'(1);
   assign last_col = (col_next >= width_ff);
   assign last_row = (row_next >= height_ff);

   always_comb begin
      col_pos_in = col_pos_ff;
      row_pos_in = row_pos_ff;
      if (req_accept) begin
         if (last_col) begin
            col_pos_in = '0;
            row_pos_in = last_row ? '0 : RPW'(row_next);
         end else begin
            col_pos_in = CPW'(col_next);
         end
      end
   end

   // history rows above the frame top are blanked
   always_comb begin
      if (row_pos_ff > RPW'(3)) begin
         keep = 4'b1111;
      end else begin
         case (row_pos_ff[1:0])
            2'd0:    keep = 4'b0000;
            2'd1:    keep = 4'b1000;
            2'd2:    keep = 4'b1100;
            default: keep = 4'b1110;
         endcase
      end
   end

   // ---------------------------------------------------------- line history
   bgmc_line_buffer #(
      .DEPTH (MAX_WIDTH),
      .AW    (CPW)
   ) u_line_buffer (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_accept),
      .rd_addr (col_pos_ff),
      .wr_en   (s1_fire),
      .wr_addr (s1_col_ff),
      .wr_data (column[HIST_W:1]),
      .rd_data (hist_rd)
   );

   // ---------------------------------------------------------- window stage
   assign column   = {s1_pix_ff, hist_rd & s1_keep_ff};
   assign win_base = s1_first_col_ff ? '0 : win_ff;
   assign win_new  = {column, win_base[WIN_W-1:HIST_W+1]};
   assign below    = (win_new >> 1) & bgmc_pkg::UPPER_ROWS_MASK;

   // also score the windows hanging past the right and bottom edges
   always_comb begin
      add = 3'(bgmc_pkg::glyph_hit(win_new));
      if (s1_last_col_ff) begin
         add = add + 3'(bgmc_pkg::glyph_hit(win_new >> (HIST_W + 1)));
      end
      if (s1_last_row_ff) begin
         add = add + 3'(bgmc_pkg::glyph_hit(below));
         if (s1_last_col_ff) begin
            add = add + 3'(bgmc_pkg::glyph_hit(below >> (HIST_W + 1)));
         end
      end
   end

   assign sum       = {1'b0, count_ff} + (COUNT_W + 1)'(add);
   assign count_sat = (sum > {1'b0, bgmc_pkg::COUNT_MAX}) ? bgmc_pkg::COUNT_MAX
                                                          : sum[COUNT_W-1:0];

   always_comb begin
      s1_valid_in = s1_valid_ff;
      win_in      = win_ff;
      count_in    = count_ff;
      if (s1_fire) begin
         s1_valid_in = 1'b0;
         win_in      = win_new;
         count_in    = (s1_last_col_ff && s1_last_row_ff) ? '0 : count_sat;
      end
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end
   end

   // --------------------------------------------------------- result output
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (s1_fire && s1_last_col_ff && s1_last_row_ff) begin
         rsp_valid_in = 1'b1;
      end
   end

   assign rsp_if.valid               = rsp_valid_ff;
   assign rsp_if.payload.match_count = rsp_count_ff;

   // ------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= WSZ_W'(RST_WIDTH);
         height_ff    <= HSZ_W'(RST_HEIGHT);
         col_pos_ff   <= '0;
         row_pos_ff   <= '0;
         s1_valid_ff  <= 1'b0;
         win_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         col_pos_ff   <= col_pos_in;
         row_pos_ff   <= row_pos_in;
         s1_valid_ff  <= s1_valid_in;
         win_ff       <= win_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_pix_ff       <= req_if.payload.pixel_set;
         s1_col_ff       <= col_pos_ff;
         s1_keep_ff      <= keep;
         s1_first_col_ff <= (col_pos_ff == '0);
         s1_last_col_ff  <= last_col;
         s1_last_row_ff  <= last_row;
      end
      if (s1_fire && s1_last_col_ff && s1_last_row_ff) begin
         rsp_count_ff <= count_sat;
      end
   end

endmodule

// File: rtl/bgmc_line_buffer.sv
// ----------------------------------------------------------------------------
// bgmc_line_buffer
// Per-column row history memory with registered read and a write-to-read
// bypass for a read and write of the same column at the same edge.
// ----------------------------------------------------------------------------
module bgmc_line_buffer #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      rd_en,
   input  logic [AW-1:0]             rd_addr,
   input  logic                      wr_en,
   input  logic [AW-1:0]             wr_addr,
   input  logic [bgmc_pkg::HIST_W-1:0] wr_data,
   output logic [bgmc_pkg::HIST_W-1:0] rd_data
);

   logic [bgmc_pkg::HIST_W-1:0] mem [DEPTH];
   logic [bgmc_pkg::HIST_W-1:0] q_ff;
   logic [bgmc_pkg::HIST_W-1:0] byp_data_ff;
   logic                        byp_ff;

   // memory write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         q_ff        <= mem[rd_addr];
         byp_data_ff <= wr_data;
      end
   end

   // same-column collision: the read must see the data written this edge
   always_ff @(posedge clock) begin
      if (reset) begin
         byp_ff <= 1'b0;
      end else if (rd_en) begin
         byp_ff <= wr_en && (wr_addr == rd_addr);
      end
   end

   assign rd_data = byp_ff ? byp_data_ff : q_ff;

endmodule

// File: tb/sv/tb_binary_glyph_match_counter_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_binary_glyph_match_counter_top
// Streams binary frames one pixel per request into the glyph match counter
// and checks every per-frame match count against a cycle-free model of the
// 5x5 hit-or-miss window, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_binary_glyph_match_counter_top;

   localparam int MAX_W          = 1024;
   localparam int MAX_H          = 1024;
   localparam int PIPE_DRAIN     = 4;
   localparam int LIMIT_CYCLES   = 2000000;
   localparam int RANDOM_PIXELS  = 420;
   localparam int RANDOM_FRAMES  = 10;
   localparam int SHOWN_FAULTS   = 10;
   localparam int CFG_W          = bgmc_pkg::CFG_W;
   localparam int WIN_W          = bgmc_pkg::WIN_W;
   localparam int COUNT_W        = bgmc_pkg::COUNT_W;

   logic                    clock;
   logic                    reset;
   logic                    csr_wr_en;
   bgmc_pkg::csr_index_type csr_index;
   logic [CFG_W-1:0]        csr_wdata;

   bgmc_stream_if #(.payload_type(bgmc_pkg::req_payload_type)) req_chan ();
   bgmc_stream_if #(.payload_type(bgmc_pkg::rsp_payload_type)) rsp_chan ();

   binary_glyph_match_counter_top #(
      .MAX_WIDTH  (MAX_W),
      .MAX_HEIGHT (MAX_H)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_chan),
      .rsp_if    (rsp_chan),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // model state: registers, line history, window, positions, count
   logic [CFG_W-1:0]   width_reg  = CFG_W'(bgmc_pkg::RESET_SIZE);
   logic [CFG_W-1:0]   height_reg = CFG_W'(bgmc_pkg::RESET_SIZE);
   bit   [3:0]         hist_mem [MAX_W];
   logic [WIN_W-1:0]   win_q      = '0;
   int unsigned        col_q      = 0;
   int unsigned        row_q      = 0;
   int unsigned        count_q    = 0;

   // frame counts still to come out of the block, oldest first
   logic [COUNT_W-1:0] queued_match_counts [$];

   // frame content, indexed [row][column]
   bit [MAX_W-1:0]     frame_img [MAX_H];

   // run bookkeeping
   int                 fault_count        = 0;
   int                 frames_checked     = 0;
   int                 pixels_sent        = 0;
   int                 largest_count      = 0;
   int                 input_stall_cycles = 0;
   int                 cycle_count        = 0;
   bit                 req_burst          = 0;
   int                 rsp_hold_cycles    = 0;
   bit                 rsp_holding        = 0;
   logic [COUNT_W-1:0] head_count;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Model
   // ------------------------------------------------------------------------

   function automatic int unsigned eff_size(input logic [CFG_W-1:0] v,
                                            input int unsigned max_size);
      if (v == 0) return 1;
      if (v > max_size) return max_size;
      return v;
   endfunction

   function automatic int unsigned is_h(input logic [WIN_W-1:0] win);
      return (win == bgmc_pkg::GLYPH_PATTERN) ? 1 : 0;
   endfunction

   // advance the model by one pixel; returns 1 when the frame closes
   function automatic bit step_glyph_count(input bit pix);
      int unsigned w, h, c, r, add, sum;
      logic [3:0]       keep;
      logic [4:0]       colv;
      logic [WIN_W-1:0] below;
      bit               lc, lr;
      w = eff_size(width_reg, MAX_W);
      h = eff_size(height_reg, MAX_H);
      c = col_q;
      r = row_q;
      // history rows above the frame top read as blank
      keep = (r >= 4) ? 4'hF : 4'(4'hF << (4 - r));
      colv = {pix, hist_mem[c % MAX_W] & keep};
      hist_mem[c % MAX_W] = colv[4:1];
      if (c == 0) win_q = '0;
      win_q = {colv, win_q[WIN_W-1:5]};
      lc = (c + 1 >= w);
      lr = (r + 1 >= h);
      // normal anchor plus the windows hanging past right/bottom edges
      add = is_h(win_q);
      if (lc) add += is_h(win_q >> 5);
      if (lr) begin
         below = (win_q >> 1) & bgmc_pkg::UPPER_ROWS_MASK;
         add += is_h(below);
         if (lc) add += is_h(below >> 5);
      end
      sum = count_q + add;
      if (sum > bgmc_pkg::COUNT_MAX) sum = bgmc_pkg::COUNT_MAX;
      count_q = sum;
      if (lc) begin
         col_q = 0;
         win_q = '0;
         if (lr) begin
            queued_match_counts.push_back(COUNT_W'(count_q));
            count_q = 0;
            row_q = 0;
            return 1'b1;
         end
         row_q = r + 1;
      end else begin
         col_q = c + 1;
      end
      return 1'b0;
   endfunction

   // ------------------------------------------------------------------------
   // Frame content
   // ------------------------------------------------------------------------

   // H glyph with its top-left pixel at (x, y), blank ring cleared around it
   task automatic plant_glyph(input int x, input int y, input int w, input int h);
      int dx, dy;
      for (dy = -1; dy <= 3; dy++) begin
         for (dx = -1; dx <= 3; dx++) begin
            if (x + dx >= 0 && x + dx < w && y + dy >= 0 && y + dy < h) begin
               frame_img[y+dy][x+dx] = (dx >= 0 && dx <= 2 && dy >= 0 && dy <= 2) &&
                                       (dx != 1 || dy == 1);
            end
         end
      end
   endtask

   // noise at noise_pct percent, then glyphs; broken glyphs lose or gain a pixel
   task automatic build_frame(input int w, input int h, input int glyphs,
                              input int noise_pct, input bit broken);
      int x, y, g;
      for (y = 0; y < h; y++) begin
         frame_img[y] = '0;
         for (x = 0; x < w; x++)
            frame_img[y][x] = ($urandom_range(0, 99) < noise_pct);
      end
      if (w >= 3 && h >= 3) begin
         for (g = 0; g < glyphs; g++) begin
            x = $urandom_range(0, w - 3);
            y = $urandom_range(0, h - 3);
            plant_glyph(x, y, w, h);
            if (broken && $urandom_range(0, 1) == 1) begin
               x = x + $urandom_range(0, 2);
               y = y + $urandom_range(0, 2);
               frame_img[y][x] = ~frame_img[y][x];
            end
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------------

   function automatic int pick_gap();
      int r;
      if (req_burst) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // one pixel request; valid stays high into the next request when no gap
   task automatic send_pixel(input bit pix, output bit ended);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid             <= 1'b1;
      req_chan.payload.pixel_set <= pix;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      ended = step_glyph_count(pix);
      pixels_sent++;
   endtask

   // send n pixels of the current frame, or up to its end when n < 0
   task automatic send_from_image(input int n);
      bit ended;
      int k;
      ended = 1'b0;
      k = 0;
      while (!ended && (n < 0 || k < n)) begin
         send_pixel(frame_img[row_q][col_q], ended);
         k++;
      end
   endtask

   // stop offering, let every due count arrive, then let the pipeline drain
   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      while (queued_match_counts.size() != 0) @(posedge clock);
      repeat (PIPE_DRAIN) @(posedge clock);
   endtask

   task automatic write_csr(input bgmc_pkg::csr_index_type idx,
                            input logic [CFG_W-1:0] val);
      wait_idle();
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == bgmc_pkg::REG_IMAGE_WIDTH) width_reg = val;
      else height_reg = val;
   endtask

   task automatic set_frame_size(input int w, input int h);
      write_csr(bgmc_pkg::REG_IMAGE_WIDTH, CFG_W'(w));
      write_csr(bgmc_pkg::REG_IMAGE_HEIGHT, CFG_W'(h));
   endtask

   // ------------------------------------------------------------------------
   // Result side: ready pattern and checker
   // ------------------------------------------------------------------------

   // ready: random runs and gaps, long clean stretches, and requested hold-offs
   initial begin
      int run;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         if (rsp_hold_cycles > 0) begin
            rsp_chan.ready <= 1'b0;
            rsp_holding = 1'b1;
            repeat (rsp_hold_cycles) @(posedge clock);
            rsp_hold_cycles = 0;
            rsp_holding = 1'b0;
         end else if ($urandom_range(0, 99) < 15) begin
            rsp_chan.ready <= 1'b1;
            repeat (150) @(posedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
            run = $urandom_range(0, 99);
            rsp_chan.ready <= 1'b0;
            if (run < 80) repeat ($urandom_range(1, 2)) @(posedge clock);
            else if (run < 97) repeat ($urandom_range(3, 6)) @(posedge clock);
            else repeat ($urandom_range(20, 60)) @(posedge clock);
         end
      end
   end

   task automatic report_fault(input string what, input int want, input int got);
      fault_count++;
      if (fault_count <= SHOWN_FAULTS)
         $display("%0t ns: %s: match_count expected %0d, got %0d", $time, what, want, got);
   endtask

   // compare each accepted count with the oldest one due
   always @(posedge clock) begin
      if (!reset && req_chan.valid && !req_chan.ready) input_stall_cycles++;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (queued_match_counts.size() == 0) begin
            report_fault("count with no frame closed", -1, rsp_chan.payload.match_count);
         end else begin
            head_count = queued_match_counts.pop_front();
            frames_checked++;
            if (head_count > largest_count) largest_count = head_count;
            if (rsp_chan.payload.match_count !== head_count)
               report_fault("count mismatch", head_count, rsp_chan.payload.match_count);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("Timeout after %0d cycles, %0d counts still due",
                  cycle_count, queued_match_counts.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // default 1024 x 1024 after reset, then both sizes cut, the width below the position
   task automatic test_reset_size_and_shrink();
      frame_img[0] = '0;
      frame_img[0][7:0] = 8'b0010_1101;
      send_from_image(6);
      set_frame_size(3, 1);
      send_from_image(-1);
   endtask

   // a lone H filling a 3x3 frame, ring entirely outside the frame
   task automatic test_single_glyph();
      set_frame_size(3, 3);
      build_frame(3, 3, 0, 0, 1'b0);
      plant_glyph(0, 0, 3, 3);
      send_from_image(-1);
   endtask

   // zero sizes act as 1 x 1: every pixel closes a frame
   task automatic test_min_size_clamp();
      set_frame_size(0, 0);
      frame_img[0][0] = 1'b1;
      send_from_image(-1);
      frame_img[0][0] = 1'b0;
      send_from_image(-1);
   endtask

   // height lowered to below the current row: the row finishes, then the frame
   task automatic test_mid_frame_height_cut();
      set_frame_size(4, 6);
      build_frame(4, 6, 0, 30, 1'b0);
      plant_glyph(0, 0, 4, 6);
      send_from_image(13);
      write_csr(bgmc_pkg::REG_IMAGE_HEIGHT, CFG_W'(2));
      send_from_image(-1);
   endtask

   // register values above the maximum, then cut back part way through
   task automatic test_size_extremes();
      set_frame_size(2047, 3);
      build_frame(24, 3, 3, 1, 1'b0);
      send_from_image(24);
      write_csr(bgmc_pkg::REG_IMAGE_WIDTH, CFG_W'(8));
      send_from_image(-1);
      set_frame_size(3, 2047);
      build_frame(3, 12, 2, 1, 1'b0);
      send_from_image(24);
      write_csr(bgmc_pkg::REG_IMAGE_HEIGHT, CFG_W'(10));
      send_from_image(-1);
   endtask

   // result side held off while small frames keep coming: input must stall
   task automatic test_output_stall();
      int f;
      set_frame_size(3, 3);
      rsp_hold_cycles = 400;
      while (!rsp_holding) @(posedge clock);
      req_burst = 1'b1;
      for (f = 0; f < 24; f++) begin
         if ($urandom_range(0, 1) == 1) begin
            build_frame(3, 3, 0, 0, 1'b0);
            plant_glyph(0, 0, 3, 3);
         end else begin
            build_frame(3, 3, 0, 50, 1'b0);
         end
         send_from_image(-1);
      end
      req_burst = 1'b0;
   endtask

   // random sizes and content: mostly planted glyphs, some noise and damage
   task automatic test_random_frames();
      int w, h, pick, frames, first_pixel, glyphs;
      frames = 0;
      first_pixel = pixels_sent;
      while (pixels_sent - first_pixel < RANDOM_PIXELS || frames < RANDOM_FRAMES) begin
         // new size for most frames, otherwise frames run back to back
         if (frames == 0 || $urandom_range(0, 9) < 6) begin
            pick = $urandom_range(0, 99);
            if (pick < 75) set_frame_size($urandom_range(1, 8), $urandom_range(1, 8));
            else if (pick < 95) set_frame_size($urandom_range(9, 32), $urandom_range(3, 10));
            else set_frame_size($urandom_range(1, 3), $urandom_range(1, 3));
         end
         w = eff_size(width_reg, MAX_W);
         h = eff_size(height_reg, MAX_H);
         glyphs = $urandom_range(1, w * h / 12 + 1);
         pick = $urandom_range(0, 99);
         if (pick < 65) build_frame(w, h, glyphs, $urandom_range(0, 2), 1'b0);
         else if (pick < 80) build_frame(w, h, 0, 50, 1'b0);
         else build_frame(w, h, glyphs, $urandom_range(0, 4), 1'b1);
         req_burst = ($urandom_range(0, 3) == 0);
         // now and then shrink one size part way through the frame
         if ($urandom_range(0, 9) == 0 && w * h > 2) begin
            send_from_image($urandom_range(1, w * h - 1));
            if ($urandom_range(0, 1) == 1)
               write_csr(bgmc_pkg::REG_IMAGE_HEIGHT, CFG_W'($urandom_range(1, h)));
            else
               write_csr(bgmc_pkg::REG_IMAGE_WIDTH, CFG_W'($urandom_range(1, w)));
         end
         send_from_image(-1);
         frames++;
      end
      req_burst = 1'b0;
   endtask

   task automatic finish_run();
      wait_idle();
      repeat (10) @(posedge clock);
      $display("Checked %0d frame counts over %0d pixel requests, largest count %0d.",
               frames_checked, pixels_sent, largest_count);
      $display("Sizes 1x1 to 32x10, above-maximum registers, mid-frame cuts, %0d %s",
               input_stall_cycles, "cycles of input backpressure.");
      if (fault_count == 0 && queued_match_counts.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin
      reset                = 1'b1;
      csr_wr_en            = 1'b0;
      csr_index            = bgmc_pkg::REG_IMAGE_WIDTH;
      csr_wdata            = '0;
      req_chan.valid       = 1'b0;
      req_chan.payload     = '0;
      rsp_chan.ready       = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_reset_size_and_shrink();
      test_single_glyph();
      test_min_size_clamp();
      test_mid_frame_height_cut();
      test_size_extremes();
      test_output_stall();
      test_random_frames();
      finish_run();
   end

endmodule

// File: filelist.f
rtl/bgmc_pkg.sv
rtl/bgmc_stream_if.sv
rtl/bgmc_line_buffer.sv
rtl/binary_glyph_match_counter_top.sv
tb/sv/tb_binary_glyph_match_counter_top.sv
